### src/sdo_pkg.sv
// shared types and codes for the spectral derivative operator
`timescale 1ns / 1ps
`default_nettype none
package sdo_pkg;

  localparam int DIM_W = 11;
  localparam int IDX_W = 10;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_DIM_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HELM_A = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HELM_B = 3'd4;

  localparam logic [1:0] OP_GRAD   = 2'd0;
  localparam logic [1:0] OP_LAP    = 2'd1;
  localparam logic [1:0] OP_HELM   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OOR  = 2'd1;
  localparam logic [1:0] ST_ZDIV = 2'd2;
  localparam logic [1:0] ST_SAT  = 2'd3;

  // result fields plus what the divider tail needs to finish a helmholtz item
  typedef struct packed {
    logic signed [31:0] x_re;
    logic signed [31:0] x_im;
    logic signed [31:0] y_re;
    logic signed [31:0] y_im;
    logic signed [31:0] z_re;
    logic signed [31:0] z_im;
    logic [1:0]         status;
    logic               div;
    logic               neg_re;
    logic               neg_im;
  } side_t;

endpackage
`default_nettype wire

### src/sdo_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage, two lanes sharing a divisor
`timescale 1ns / 1ps
`default_nettype none
module sdo_div_pipe #(
  parameter int NW = 48,
  parameter int DW = 58
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [NW-1:0]   in_num_re,
  input  wire logic [NW-1:0]   in_num_im,
  input  wire logic [DW-1:0]   in_den,
  input  wire sdo_pkg::side_t  in_side,
  output logic                 out_valid,
  output logic [NW-1:0]        out_q_re,
  output logic [NW-1:0]        out_q_im,
  output sdo_pkg::side_t       out_side
);

  logic [NW-1:0]  num_re_s [0:NW];
  logic [NW-1:0]  num_im_s [0:NW];
  logic [NW-1:0]  q_re_s   [0:NW];
  logic [NW-1:0]  q_im_s   [0:NW];
  logic [DW-1:0]  rem_re_s [0:NW];
  logic [DW-1:0]  rem_im_s [0:NW];
  logic [DW-1:0]  den_s    [0:NW];
  sdo_pkg::side_t side_s   [0:NW];
  logic           vld_s    [0:NW];

  assign num_re_s[0] = in_num_re;
  assign num_im_s[0] = in_num_im;
  assign q_re_s[0]   = '0;
  assign q_im_s[0]   = '0;
  assign rem_re_s[0] = '0;
  assign rem_im_s[0] = '0;
  assign den_s[0]    = in_den;
  assign side_s[0]   = in_side;
  assign vld_s[0]    = in_valid;

  for (genvar i = 0; i < NW; i++) begin : g_step
    logic [DW:0]   sh_re, sh_im;
    logic [DW:0]   df_re, df_im;
    logic [DW-1:0] rem_re_nxt, rem_im_nxt;
    logic          bit_re, bit_im;

    always_comb begin
      sh_re = {rem_re_s[i], num_re_s[i][NW-1]};
      sh_im = {rem_im_s[i], num_im_s[i][NW-1]};
      df_re = sh_re - {1'b0, den_s[i]};
      df_im = sh_im - {1'b0, den_s[i]};
      bit_re = (sh_re >= {1'b0, den_s[i]});
      bit_im = (sh_im >= {1'b0, den_s[i]});
      rem_re_nxt = bit_re ? df_re[DW-1:0] : sh_re[DW-1:0];
      rem_im_nxt = bit_im ? df_im[DW-1:0] : sh_im[DW-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_s[i+1] <= 1'b0;
      end else if (en) begin
        vld_s[i+1] <= vld_s[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_re_s[i+1] <= {num_re_s[i][NW-2:0], 1'b0};
        num_im_s[i+1] <= {num_im_s[i][NW-2:0], 1'b0};
        q_re_s[i+1]   <= {q_re_s[i][NW-2:0], bit_re};
        q_im_s[i+1]   <= {q_im_s[i][NW-2:0], bit_im};
        rem_re_s[i+1] <= rem_re_nxt;
        rem_im_s[i+1] <= rem_im_nxt;
        den_s[i+1]    <= den_s[i];
        side_s[i+1]   <= side_s[i];
      end
    end
  end

  assign out_valid = vld_s[NW];
  assign out_q_re  = q_re_s[NW];
  assign out_q_im  = q_im_s[NW];
  assign out_side  = side_s[NW];

endmodule
`default_nettype wire

### src/spectral_derivative_operator.sv
// top level of the spectral derivative operator
`timescale 1ns / 1ps
`default_nettype none
// Applies gradient, laplacian or helmholtz inverse to one Fourier coefficient per beat.
// Fully pipelined: one beat enters every cycle while the result side does not stall. The
// restoring divider spends one stage per quotient bit. Every op travels the same path, so
// order is kept. A stall on the result side freezes the whole pipeline and holds in_stall
// high. Configuration writes are always ready and should be made while the block is empty.
module spectral_derivative_operator #(
  parameter int MAX_DIM   = 1024,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_op,
  input  wire logic [sdo_pkg::IDX_W-1:0]     in_idx_x,
  input  wire logic [sdo_pkg::IDX_W-1:0]     in_idx_y,
  input  wire logic [sdo_pkg::IDX_W-1:0]     in_idx_z,
  input  wire logic signed [31:0]            in_value_re,
  input  wire logic signed [31:0]            in_value_im,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [31:0]                 out_x_re,
  output logic signed [31:0]                 out_x_im,
  output logic signed [31:0]                 out_y_re,
  output logic signed [31:0]                 out_y_im,
  output logic signed [31:0]                 out_z_re,
  output logic signed [31:0]                 out_z_im,
  output logic [1:0]                         out_status,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [sdo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_data
);

  localparam int DIM_W = sdo_pkg::DIM_W;
  localparam int KW    = DIM_W + 1;
  localparam int GW    = KW + 32;
  localparam int KSQW  = 24;
  localparam int PW    = KSQW + 1 + 32;
  localparam int DW    = PW + 1;
  localparam int NW    = 32 + FRAC_BITS;

  function automatic logic [32:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return {1'b1, 32'h7fffffff};
    end else if (v < -64'sd2147483648) begin
      return {1'b1, 32'h80000000};
    end else begin
      return {1'b0, v[31:0]};
    end
  endfunction

  // returns {out of range, wavenumber}
  function automatic logic [KW:0] axis_k(input logic [sdo_pkg::IDX_W-1:0] idx,
                                         input logic [DIM_W-1:0] dim);
    logic [DIM_W-1:0]   eff;
    logic signed [KW-1:0] k;
    logic               o;
    eff = (32'(dim) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : dim;
    o = ({1'b0, idx} >= eff);
    if ({1'b0, idx} <= (eff >> 1)) begin
      k = $signed({2'b0, idx});
    end else begin
      k = $signed({2'b0, idx}) - $signed({1'b0, eff});
    end
    return {o, k};
  endfunction

  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // configuration
  logic [DIM_W-1:0]   dim_x_r, dim_y_r, dim_z_r;
  logic signed [31:0] helm_a_r, helm_b_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_x_r  <= DIM_W'(64);
      dim_y_r  <= DIM_W'(64);
      dim_z_r  <= DIM_W'(64);
      helm_a_r <= 32'sd65536;
      helm_b_r <= 32'sd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sdo_pkg::CFG_DIM_X:  dim_x_r  <= cfg_data[DIM_W-1:0];
        sdo_pkg::CFG_DIM_Y:  dim_y_r  <= cfg_data[DIM_W-1:0];
        sdo_pkg::CFG_DIM_Z:  dim_z_r  <= cfg_data[DIM_W-1:0];
        sdo_pkg::CFG_HELM_A: helm_a_r <= cfg_data;
        sdo_pkg::CFG_HELM_B: helm_b_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: wavenumbers and range check
  logic [KW:0] ax_x, ax_y, ax_z;
  always_comb begin
    ax_x = axis_k(in_idx_x, dim_x_r);
    ax_y = axis_k(in_idx_y, dim_y_r);
    ax_z = axis_k(in_idx_z, dim_z_r);
  end

  logic                 v1_r, oor1_r;
  logic [1:0]           op1_r;
  logic signed [KW-1:0] kx1_r, ky1_r, kz1_r;
  logic signed [31:0]   re1_r, im1_r;

  // stage 2: squares and gradient products
  logic                 v2_r, oor2_r;
  logic [1:0]           op2_r;
  logic [KSQW-1:0]      sqx2_r, sqy2_r, sqz2_r;
  logic signed [GW-1:0] pxr2_r, pxi2_r, pyr2_r, pyi2_r, pzr2_r, pzi2_r;
  logic signed [31:0]   re2_r, im2_r;
  logic signed [2*KW-1:0] sqx_w, sqy_w, sqz_w;

  // stage 3: |k|^2 and saturated gradient
  logic                 v3_r, oor3_r, gsat3_r;
  logic [1:0]           op3_r;
  logic [KSQW-1:0]      ksq3_r;
  logic signed [31:0]   g3_r [0:5];
  logic signed [31:0]   re3_r, im3_r;
  logic [32:0]          gs_w [0:5];
  logic [KSQW+1:0]      ksq_sum;

  // stage 4: laplacian products and b*|k|^2
  logic                 v4_r, oor4_r, gsat4_r, kz4_r;
  logic [1:0]           op4_r;
  logic signed [31:0]   g4_r [0:5];
  logic signed [31:0]   re4_r, im4_r;
  logic signed [PW-1:0] lre4_r, lim4_r, bk4_r;
  logic signed [KSQW:0] ksq_s;

  // stage 5: divisor
  logic                 v5_r, oor5_r, gsat5_r, kz5_r;
  logic [1:0]           op5_r;
  logic signed [31:0]   g5_r [0:5];
  logic signed [31:0]   re5_r, im5_r;
  logic signed [PW-1:0] lre5_r, lim5_r;
  logic signed [DW-1:0] d5_r;

  always_comb begin
    sqx_w = kx1_r * kx1_r;
    sqy_w = ky1_r * ky1_r;
    sqz_w = kz1_r * kz1_r;
    ksq_sum = (KSQW+2)'(sqx2_r) + (KSQW+2)'(sqy2_r) + (KSQW+2)'(sqz2_r);
    gs_w[0] = sat32(-(64'(pxi2_r)));
    gs_w[1] = sat32(64'(pxr2_r));
    gs_w[2] = sat32(-(64'(pyi2_r)));
    gs_w[3] = sat32(64'(pyr2_r));
    gs_w[4] = sat32(-(64'(pzi2_r)));
    gs_w[5] = sat32(64'(pzr2_r));
    ksq_s = $signed({1'b0, ksq3_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oor1_r <= ax_x[KW] | ax_y[KW] | ax_z[KW];
      op1_r  <= in_op;
      kx1_r  <= ax_x[KW-1:0];
      ky1_r  <= ax_y[KW-1:0];
      kz1_r  <= ax_z[KW-1:0];
      re1_r  <= in_value_re;
      im1_r  <= in_value_im;

      oor2_r <= oor1_r;
      op2_r  <= op1_r;
      sqx2_r <= sqx_w[KSQW-1:0];
      sqy2_r <= sqy_w[KSQW-1:0];
      sqz2_r <= sqz_w[KSQW-1:0];
      pxr2_r <= kx1_r * re1_r;
      pxi2_r <= kx1_r * im1_r;
      pyr2_r <= ky1_r * re1_r;
      pyi2_r <= ky1_r * im1_r;
      pzr2_r <= kz1_r * re1_r;
      pzi2_r <= kz1_r * im1_r;
      re2_r  <= re1_r;
      im2_r  <= im1_r;

      oor3_r  <= oor2_r;
      op3_r   <= op2_r;
      ksq3_r  <= ksq_sum[KSQW-1:0];
      gsat3_r <= gs_w[0][32] | gs_w[1][32] | gs_w[2][32] |
                 gs_w[3][32] | gs_w[4][32] | gs_w[5][32];
      for (int j = 0; j < 6; j++) begin
        g3_r[j] <= gs_w[j][31:0];
        g4_r[j] <= g3_r[j];
        g5_r[j] <= g4_r[j];
      end
      re3_r <= re2_r;
      im3_r <= im2_r;

      oor4_r  <= oor3_r;
      op4_r   <= op3_r;
      gsat4_r <= gsat3_r;
      kz4_r   <= (ksq3_r == '0);
      re4_r   <= re3_r;
      im4_r   <= im3_r;
      lre4_r  <= ksq_s * re3_r;
      lim4_r  <= ksq_s * im3_r;
      bk4_r   <= ksq_s * helm_b_r;

      oor5_r  <= oor4_r;
      op5_r   <= op4_r;
      gsat5_r <= gsat4_r;
      kz5_r   <= kz4_r;
      re5_r   <= re4_r;
      im5_r   <= im4_r;
      lre5_r  <= lre4_r;
      lim5_r  <= lim4_r;
      d5_r    <= DW'(helm_a_r) - DW'(bk4_r);
    end
  end

  // result select ahead of the divider
  sdo_pkg::side_t side_w;
  logic [32:0]    ls_re, ls_im;
  logic [31:0]    mag_re, mag_im;
  logic [DW-1:0]  mag_d;
  logic [NW-1:0]  num_re, num_im;

  always_comb begin
    ls_re  = sat32(-(64'(lre5_r)));
    ls_im  = sat32(-(64'(lim5_r)));
    mag_re = re5_r[31] ? 32'(-re5_r) : 32'(re5_r);
    mag_im = im5_r[31] ? 32'(-im5_r) : 32'(im5_r);
    mag_d  = d5_r[DW-1] ? DW'(-d5_r) : DW'(d5_r);
    num_re = {mag_re, {FRAC_BITS{1'b0}}};
    num_im = {mag_im, {FRAC_BITS{1'b0}}};
    side_w        = '0;
    side_w.status = sdo_pkg::ST_OK;
    side_w.neg_re = re5_r[31] ^ d5_r[DW-1];
    side_w.neg_im = im5_r[31] ^ d5_r[DW-1];
    if (oor5_r) begin
      side_w.status = sdo_pkg::ST_OOR;
    end else begin
      case (op5_r)
        sdo_pkg::OP_GRAD: begin
          side_w.x_re   = g5_r[0];
          side_w.x_im   = g5_r[1];
          side_w.y_re   = g5_r[2];
          side_w.y_im   = g5_r[3];
          side_w.z_re   = g5_r[4];
          side_w.z_im   = g5_r[5];
          side_w.status = gsat5_r ? sdo_pkg::ST_SAT : sdo_pkg::ST_OK;
        end
        sdo_pkg::OP_LAP: begin
          side_w.x_re   = ls_re[31:0];
          side_w.x_im   = ls_im[31:0];
          side_w.status = (ls_re[32] | ls_im[32]) ? sdo_pkg::ST_SAT : sdo_pkg::ST_OK;
        end
        sdo_pkg::OP_HELM: begin
          if (kz5_r) begin
            side_w.x_re = re5_r;
            side_w.x_im = im5_r;
          end else if (d5_r == '0) begin
            side_w.status = sdo_pkg::ST_ZDIV;
          end else begin
            side_w.div = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  logic           dv_valid;
  logic [NW-1:0]  dq_re, dq_im;
  sdo_pkg::side_t dside;

  sdo_div_pipe #(
    .NW(NW),
    .DW(DW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v5_r),
    .in_num_re (num_re),
    .in_num_im (num_im),
    .in_den    (mag_d),
    .in_side   (side_w),
    .out_valid (dv_valid),
    .out_q_re  (dq_re),
    .out_q_im  (dq_im),
    .out_side  (dside)
  );

  // sign, saturate and pick the quotient for divided beats
  logic [32:0] qs_re, qs_im;
  logic signed [31:0] x_re_nxt, x_im_nxt;
  logic [1:0]  st_nxt;

  always_comb begin
    qs_re = sat32(dside.neg_re ? -(64'(dq_re)) : 64'(dq_re));
    qs_im = sat32(dside.neg_im ? -(64'(dq_im)) : 64'(dq_im));
    if (dside.div) begin
      x_re_nxt = qs_re[31:0];
      x_im_nxt = qs_im[31:0];
      st_nxt   = (qs_re[32] | qs_im[32]) ? sdo_pkg::ST_SAT : sdo_pkg::ST_OK;
    end else begin
      x_re_nxt = dside.x_re;
      x_im_nxt = dside.x_im;
      st_nxt   = dside.status;
    end
  end

  logic               out_valid_r;
  logic signed [31:0] x_re_r, x_im_r, y_re_r, y_im_r, z_re_r, z_im_r;
  logic [1:0]         status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_re_r   <= x_re_nxt;
      x_im_r   <= x_im_nxt;
      y_re_r   <= dside.y_re;
      y_im_r   <= dside.y_im;
      z_re_r   <= dside.z_re;
      z_im_r   <= dside.z_im;
      status_r <= st_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_x_re   = x_re_r;
  assign out_x_im   = x_im_r;
  assign out_y_re   = y_re_r;
  assign out_y_im   = y_im_r;
  assign out_z_re   = z_re_r;
  assign out_z_im   = z_im_r;
  assign out_status = status_r;

endmodule
`default_nettype wire
